// File: src/rfv_pkg.sv
// Shared types and constants for the random forest vote classifier.
// Used by rfv_stores, random_forest_vote_classifier and rfv_checker.
package rfv_pkg;

	// Forest geometry.
	localparam int NUM_FEATURES   = 2048;
	localparam int MAX_TREES      = 128;
	localparam int NODES_PER_TREE = 256;
	localparam int MAX_DEPTH      = 32;

	// Derived widths.
	localparam int FEAT_W   = $clog2(NUM_FEATURES);
	localparam int TREE_W   = $clog2(MAX_TREES);
	localparam int NODE_W   = $clog2(NODES_PER_TREE);
	localparam int NADDR_W  = TREE_W + NODE_W;
	localparam int TCNT_W   = $clog2(MAX_TREES + 1);
	localparam int STEP_W   = $clog2(MAX_DEPTH + 1);

	// Fixed field widths of an item.
	localparam int OPC_W    = 2;
	localparam int FIDX_W   = 11;
	localparam int VAL_W    = 16;
	localparam int TNUM_W   = 7;
	localparam int NNUM_W   = 8;
	localparam int CLS_W    = 2;
	localparam int VOTE_W   = 8;
	localparam int CFG_W    = 8;
	localparam int IN_W     = 88;
	localparam int OUT_W    = 24;

	// Reset value of the tree count register.
	localparam logic [CFG_W-1:0] NUM_TREES_RST = 8'd100;

	// Operation codes.
	localparam logic [OPC_W-1:0] OP_FEAT  = 2'd0;
	localparam logic [OPC_W-1:0] OP_NODE  = 2'd1;
	localparam logic [OPC_W-1:0] OP_CLASS = 2'd2;

	// Leaf classes that vote.
	localparam logic [CLS_W-1:0] CLS_A = 2'd1;
	localparam logic [CLS_W-1:0] CLS_B = 2'd2;

	// One stored tree node.
	typedef struct packed {
		logic              leaf;
		logic [FIDX_W-1:0] feature;
		logic [VAL_W-1:0]  threshold;
		logic [NNUM_W-1:0] left;
		logic [NNUM_W-1:0] right;
		logic [CLS_W-1:0]  cls;
	} node_t;

	// Write and read requests from the sequencer to the stores.
	typedef struct packed {
		logic               feat_we;
		logic [FEAT_W-1:0]  feat_waddr;
		logic [VAL_W-1:0]   feat_wdata;
		logic               node_we;
		logic [NADDR_W-1:0] node_waddr;
		node_t              node_wdata;
		logic               feat_re;
		logic [FEAT_W-1:0]  feat_raddr;
		logic               node_re;
		logic [NADDR_W-1:0] node_raddr;
	} mem_req_t;

endpackage

// File: src/rfv_stores.sv
// Feature store and node store of the forest, one write and one
// registered read port each. Depends on rfv_pkg.
module rfv_stores (
	input  logic                        clk,
	input  rfv_pkg::mem_req_t           req,
	output logic [rfv_pkg::VAL_W-1:0]   feat_rdata,
	output rfv_pkg::node_t              node_rdata
);

	logic [rfv_pkg::VAL_W-1:0] feat_mem [rfv_pkg::NUM_FEATURES];
	rfv_pkg::node_t            node_mem [rfv_pkg::MAX_TREES * rfv_pkg::NODES_PER_TREE];

	// Feature store port.
	always_ff @(posedge clk) begin
		if (req.feat_we) begin
			feat_mem[req.feat_waddr] <= req.feat_wdata;
		end
		if (req.feat_re) begin
			feat_rdata <= feat_mem[req.feat_raddr];
		end
	end

	// Node store port.
	always_ff @(posedge clk) begin
		if (req.node_we) begin
			node_mem[req.node_waddr] <= req.node_wdata;
		end
		if (req.node_re) begin
			node_rdata <= node_mem[req.node_raddr];
		end
	end

endmodule

// File: src/random_forest_vote_classifier.sv
// Random forest vote classifier: loads features and tree nodes, then walks
// the trees one node at a time through the two stores and counts votes.
// Load items are accepted one per cycle, back to back, while the block is idle.
// A classify item walks every active tree in turn; each step is a node store
// read, a feature store read and a compare.
// No item is accepted while a classify walk runs; the result waits in an output register.
// arst_n clears control state and sets num_trees to 100; stores are not cleared.
module random_forest_vote_classifier (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration: num_trees.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rfv_pkg::CFG_W-1:0]     cfg_data,
	// Input items.
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// tdata: feature_index[10:0], feature_value[26:11], tree_number[33:27],
	// node_number[41:34], node_is_leaf[42], node_feature[53:43],
	// node_threshold[69:54], left_child[77:70], right_child[85:78],
	// leaf_class[87:86].
	input  logic [rfv_pkg::IN_W-1:0]      s_axis_tdata,
	// tuser: opcode[1:0].
	input  logic [rfv_pkg::OPC_W-1:0]     s_axis_tuser,
	// Result items.
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// tdata: winning_class[0], votes_a[8:1], votes_b[16:9], depth_error[17],
	// zero[23:18].
	output logic [rfv_pkg::OUT_W-1:0]     m_axis_tdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROOT,
		S_NODE,
		S_CMP,
		S_DONE
	} state_t;

	state_t                        state_q;
	logic [rfv_pkg::CFG_W-1:0]     num_trees_q;
	logic [rfv_pkg::TCNT_W-1:0]    trees_q;
	logic [rfv_pkg::TREE_W-1:0]    tree_q;
	logic [rfv_pkg::STEP_W-1:0]    step_q;
	logic                          first_q;
	logic [rfv_pkg::VAL_W-1:0]     thr_q;
	logic [rfv_pkg::NNUM_W-1:0]    left_q;
	logic [rfv_pkg::NNUM_W-1:0]    right_q;
	logic                          fzero_q;
	logic [rfv_pkg::TCNT_W-1:0]    cnt_a_q;
	logic [rfv_pkg::TCNT_W-1:0]    cnt_b_q;
	logic                          err_run_q;
	logic                          m_valid_q;
	logic                          win_q;
	logic [rfv_pkg::VOTE_W-1:0]    votes_a_q;
	logic [rfv_pkg::VOTE_W-1:0]    votes_b_q;
	logic                          derr_q;

	// Input fields.
	logic [rfv_pkg::FIDX_W-1:0]    in_fidx;
	logic [rfv_pkg::VAL_W-1:0]     in_fval;
	logic [rfv_pkg::TNUM_W-1:0]    in_tree;
	logic [rfv_pkg::NNUM_W-1:0]    in_node;
	rfv_pkg::node_t                in_nd;

	logic                          accept;
	rfv_pkg::mem_req_t             req;
	logic [rfv_pkg::VAL_W-1:0]     feat_rdata;
	rfv_pkg::node_t                node_rdata;
	logic [rfv_pkg::VAL_W-1:0]     fval;
	logic [rfv_pkg::NNUM_W-1:0]    child;
	logic                          tree_end;
	logic                          vote_a;
	logic                          vote_b;
	logic                          walk_err;
	logic                          last_tree;
	logic [rfv_pkg::TCNT_W-1:0]    trees_clamped;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Unpack the input item.
	assign in_fidx          = s_axis_tdata[10:0];
	assign in_fval          = s_axis_tdata[26:11];
	assign in_tree          = s_axis_tdata[33:27];
	assign in_node          = s_axis_tdata[41:34];
	assign in_nd.leaf       = s_axis_tdata[42];
	assign in_nd.feature    = s_axis_tdata[53:43];
	assign in_nd.threshold  = s_axis_tdata[69:54];
	assign in_nd.left       = s_axis_tdata[77:70];
	assign in_nd.right      = s_axis_tdata[85:78];
	assign in_nd.cls        = s_axis_tdata[87:86];

	// Tree count, clamped to the size of the forest.
	always_comb begin
		if (int'(num_trees_q) > rfv_pkg::MAX_TREES) begin
			trees_clamped = rfv_pkg::TCNT_W'(rfv_pkg::MAX_TREES);
		end else begin
			trees_clamped = rfv_pkg::TCNT_W'(num_trees_q);
		end
	end

	// Shared compare: pick the child from the fetched feature.
	assign fval  = fzero_q ? '0 : feat_rdata;
	assign child = (fval < thr_q) ? left_q : right_q;

	assign last_tree = (rfv_pkg::TCNT_W'(tree_q) + rfv_pkg::TCNT_W'(1)) == trees_q;

	// End of one walk and its outcome.
	always_comb begin
		tree_end = 1'b0;
		vote_a   = 1'b0;
		vote_b   = 1'b0;
		walk_err = 1'b0;
		unique case (state_q)
			S_NODE: begin
				if (!first_q && node_rdata.leaf) begin
					tree_end = 1'b1;
					vote_a   = (node_rdata.cls == rfv_pkg::CLS_A);
					vote_b   = (node_rdata.cls == rfv_pkg::CLS_B);
				end else if (!first_q && step_q == rfv_pkg::STEP_W'(rfv_pkg::MAX_DEPTH)) begin
					tree_end = 1'b1;
					walk_err = 1'b1;
				end
			end
			S_CMP: begin
				if (int'(child) >= rfv_pkg::NODES_PER_TREE) begin
					tree_end = 1'b1;
					walk_err = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Store requests: loads in idle, reads during the walk.
	always_comb begin
		req            = '0;
		req.feat_waddr = rfv_pkg::FEAT_W'(in_fidx);
		req.feat_wdata = in_fval;
		req.node_waddr = {rfv_pkg::TREE_W'(in_tree), rfv_pkg::NODE_W'(in_node)};
		req.node_wdata = in_nd;
		req.feat_raddr = rfv_pkg::FEAT_W'(node_rdata.feature);
		req.node_raddr = {tree_q, rfv_pkg::NODE_W'(child)};
		if (accept && s_axis_tuser == rfv_pkg::OP_FEAT) begin
			req.feat_we = (int'(in_fidx) < rfv_pkg::NUM_FEATURES);
		end
		if (accept && s_axis_tuser == rfv_pkg::OP_NODE) begin
			req.node_we = (int'(in_tree) < rfv_pkg::MAX_TREES) &&
				(int'(in_node) < rfv_pkg::NODES_PER_TREE);
		end
		unique case (state_q)
			S_ROOT: begin
				req.node_re    = 1'b1;
				req.node_raddr = {tree_q, rfv_pkg::NODE_W'(0)};
			end
			S_NODE: begin
				req.feat_re = !tree_end;
			end
			S_CMP: begin
				req.node_re = !tree_end;
			end
			default: begin
			end
		endcase
	end

	rfv_stores u_stores (
		.clk        (clk),
		.req        (req),
		.feat_rdata (feat_rdata),
		.node_rdata (node_rdata)
	);

	// Sequencer, counters and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			num_trees_q <= rfv_pkg::NUM_TREES_RST;
			trees_q     <= '0;
			tree_q      <= '0;
			step_q      <= '0;
			first_q     <= 1'b1;
			thr_q       <= '0;
			left_q      <= '0;
			right_q     <= '0;
			fzero_q     <= 1'b0;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			err_run_q   <= 1'b0;
			m_valid_q   <= 1'b0;
			win_q       <= 1'b0;
			votes_a_q   <= '0;
			votes_b_q   <= '0;
			derr_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				num_trees_q <= cfg_data;
			end
			// Drop a taken result unless a new one is loaded in its place.
			if (m_valid_q && m_axis_tready && state_q != S_DONE) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && s_axis_tuser == rfv_pkg::OP_CLASS) begin
						trees_q   <= trees_clamped;
						tree_q    <= '0;
						step_q    <= '0;
						first_q   <= 1'b1;
						cnt_a_q   <= '0;
						cnt_b_q   <= '0;
						err_run_q <= 1'b0;
						state_q   <= (trees_clamped == '0) ? S_DONE : S_ROOT;
					end
				end
				S_ROOT: begin
					state_q <= S_NODE;
				end
				S_NODE: begin
					if (!tree_end) begin
						thr_q   <= node_rdata.threshold;
						left_q  <= node_rdata.left;
						right_q <= node_rdata.right;
						fzero_q <= (int'(node_rdata.feature) >= rfv_pkg::NUM_FEATURES);
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (!tree_end) begin
						step_q  <= step_q + rfv_pkg::STEP_W'(1);
						first_q <= 1'b0;
						state_q <= S_NODE;
					end
				end
				S_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						win_q     <= !(cnt_a_q > cnt_b_q);
						votes_a_q <= rfv_pkg::VOTE_W'(cnt_a_q);
						votes_b_q <= rfv_pkg::VOTE_W'(cnt_b_q);
						derr_q    <= err_run_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// Close a walk: count its vote and move to the next tree.
			if (tree_end) begin
				if (vote_a) begin
					cnt_a_q <= cnt_a_q + rfv_pkg::TCNT_W'(1);
				end
				if (vote_b) begin
					cnt_b_q <= cnt_b_q + rfv_pkg::TCNT_W'(1);
				end
				if (walk_err) begin
					err_run_q <= 1'b1;
				end
				step_q  <= '0;
				first_q <= 1'b1;
				if (last_tree) begin
					state_q <= S_DONE;
				end else begin
					tree_q  <= tree_q + rfv_pkg::TREE_W'(1);
					state_q <= S_ROOT;
				end
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'b0, derr_q, votes_b_q, votes_a_q, win_q};

endmodule

// File: src/rfv_checker.sv
// Port-level checks of the random forest vote classifier, bound to the top.
// Depends on rfv_pkg and random_forest_vote_classifier.
module rfv_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [rfv_pkg::OPC_W-1:0]     s_axis_tuser,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [rfv_pkg::OUT_W-1:0]     m_axis_tdata
);

	// A load or an unused code never makes the block busy.
	a_load_keeps_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser != rfv_pkg::OP_CLASS
		|=> s_axis_tready)
		else $error("ready dropped after a load item");

	// A classify item starts a walk that blocks further input.
	a_class_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == rfv_pkg::OP_CLASS
		|=> !s_axis_tready)
		else $error("classify item did not start a walk");

	// The winner agrees with the vote counts.
	a_winner: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[0] == !(m_axis_tdata[8:1] > m_axis_tdata[16:9]))
		else $error("winning class disagrees with votes");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

endmodule

bind random_forest_vote_classifier rfv_checker u_rfv_checker (.*);

// File: verif/tb.sv
// Testbench for random_forest_vote_classifier: a directed table, then random forests.
// Depends on rfv_pkg and the block; vote results are predicted from local store copies or written by hand.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rfv_pkg::*;

	localparam logic [OPC_W-1:0] OP_NONE   = 2'd3;
	localparam logic [CLS_W-1:0] CLS_NONE  = 2'd0;
	localparam logic [CLS_W-1:0] CLS_SPARE = 2'd3;
	localparam logic             WIN_A     = 1'b0;
	localparam logic             WIN_B     = 1'b1;
	localparam int RANDOM_ITEMS = 800;
	localparam int CALM_TAIL    = 120;
	localparam int POOL_SIZE    = 16;
	// The stimulus holds at most about 400 votes, so the limit leaves room even
	// for a full forest of 128 looping trees.
	localparam int CYCLE_LIMIT  = 20_000_000;
	localparam int WALK_ERR     = -1;
	localparam int WALK_MISS    = -2;

	typedef enum logic [1:0] {MISS_NONE, MISS_NODE, MISS_FEAT} miss_t;
	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	// Input item fields, highest bits first, as they sit in s_axis_tdata.
	typedef struct packed {
		logic [CLS_W-1:0]  leaf_class;
		logic [NNUM_W-1:0] right_child;
		logic [NNUM_W-1:0] left_child;
		logic [VAL_W-1:0]  node_threshold;
		logic [FIDX_W-1:0] node_feature;
		logic              node_is_leaf;
		logic [NNUM_W-1:0] node_number;
		logic [TNUM_W-1:0] tree_number;
		logic [VAL_W-1:0]  feature_value;
		logic [FIDX_W-1:0] feature_index;
	} load_t;

	// Result item fields, highest bits first, as they sit in m_axis_tdata.
	typedef struct packed {
		logic [5:0]        zero;
		logic              depth_error;
		logic [VOTE_W-1:0] votes_b;
		logic [VOTE_W-1:0] votes_a;
		logic              winning_class;
	} vote_t;

	typedef struct {
		row_kind_t         kind;
		logic [OPC_W-1:0]  op;
		load_t             ld;
		logic [CFG_W-1:0]  cfg;
		bit                typed;
		vote_t             want;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [IN_W-1:0]     s_axis_tdata;
	logic [OPC_W-1:0]    s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OUT_W-1:0]    m_axis_tdata;

	// Local copies of the stores and the tree count register.
	logic [VAL_W-1:0]    feat_copy [NUM_FEATURES];
	bit                  feat_written [NUM_FEATURES];
	node_t               node_copy [MAX_TREES*NODES_PER_TREE];
	bit                  node_written [MAX_TREES*NODES_PER_TREE];
	int                  trees_reg;

	vote_t               pending_votes[$];
	dir_row_t            dir_rows[$];
	int                  feat_pool [POOL_SIZE];
	int                  fail_count = 0;
	int                  item_count = 0;
	int                  cycles = 0;
	bit                  quiet = 1'b0;
	bit                  calm = 1'b0;

	always #2 clk = ~clk;

	random_forest_vote_classifier u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Walk one tree from node 0. Returns the leaf class, WALK_ERR on the depth
	// bound or a bad child, or WALK_MISS with the first unwritten entry it needs.
	function automatic int walk_tree(input int tree, output miss_t mk, output int ma);
		int base;
		int node;
		int nxt;
		node_t n;
		node_t c;
		logic [VAL_W-1:0] fval;
		base = tree * NODES_PER_TREE;
		node = 0;
		mk = MISS_NONE;
		ma = 0;
		for (int step = 0; step < MAX_DEPTH; step++) begin
			if (!node_written[base + node]) begin
				mk = MISS_NODE;
				ma = base + node;
				return WALK_MISS;
			end
			n = node_copy[base + node];
			if (n.feature < NUM_FEATURES && !feat_written[n.feature]) begin
				mk = MISS_FEAT;
				ma = int'(n.feature);
				return WALK_MISS;
			end
			fval = (n.feature < NUM_FEATURES) ? feat_copy[n.feature] : '0;
			nxt = (fval < n.threshold) ? int'(n.left) : int'(n.right);
			if (nxt >= NODES_PER_TREE)
				return WALK_ERR;
			node = nxt;
			// The node just stepped onto is tested for a leaf only now.
			if (!node_written[base + node]) begin
				mk = MISS_NODE;
				ma = base + node;
				return WALK_MISS;
			end
			c = node_copy[base + node];
			if (c.leaf)
				return int'(c.cls);
		end
		return WALK_ERR;
	endfunction

	// Count the votes of the active trees; stops early on an unwritten entry.
	function automatic vote_t forest_vote(output miss_t mk, output int ma);
		int trees;
		int va;
		int vb;
		int cls;
		bit err;
		vote_t v;
		trees = (trees_reg > MAX_TREES) ? MAX_TREES : trees_reg;
		va = 0;
		vb = 0;
		err = 1'b0;
		mk = MISS_NONE;
		ma = 0;
		for (int t = 0; t < trees && mk == MISS_NONE; t++) begin
			cls = walk_tree(t, mk, ma);
			if (cls == WALK_ERR)
				err = 1'b1;
			else if (cls == int'(CLS_A))
				va++;
			else if (cls == int'(CLS_B))
				vb++;
		end
		v.zero = '0;
		v.winning_class = (va > vb) ? WIN_A : WIN_B;
		v.votes_a = (va > 255) ? 8'd255 : VOTE_W'(va);
		v.votes_b = (vb > 255) ? 8'd255 : VOTE_W'(vb);
		v.depth_error = err;
		return v;
	endfunction

	function automatic load_t feat_item(input int idx, input logic [VAL_W-1:0] val);
		load_t ld;
		ld = '0;
		ld.feature_index = FIDX_W'(idx);
		ld.feature_value = val;
		return ld;
	endfunction

	function automatic load_t node_item(input int tree, input int node, input bit leaf,
			input int feat, input logic [VAL_W-1:0] thr, input int left, input int right,
			input logic [CLS_W-1:0] cls);
		load_t ld;
		ld = '0;
		ld.tree_number = TNUM_W'(tree);
		ld.node_number = NNUM_W'(node);
		ld.node_is_leaf = leaf;
		ld.node_feature = FIDX_W'(feat);
		ld.node_threshold = thr;
		ld.left_child = NNUM_W'(left);
		ld.right_child = NNUM_W'(right);
		ld.leaf_class = cls;
		return ld;
	endfunction

	// Extreme values now and then, otherwise any 16-bit word.
	function automatic logic [VAL_W-1:0] pick_word();
		case ($urandom_range(0, 7))
		0: return 16'h0000;
		1: return 16'hFFFF;
		default: return VAL_W'($urandom());
		endcase
	endfunction

	function automatic load_t random_node(input int tree, input int node);
		int feat;
		feat = ($urandom_range(0, 7) == 0) ? $urandom_range(0, NUM_FEATURES - 1)
			: feat_pool[$urandom_range(0, POOL_SIZE - 1)];
		return node_item(tree, node, 1'($urandom_range(0, 1)), feat, pick_word(),
			$urandom_range(0, 7), $urandom_range(0, 7), CLS_W'($urandom_range(0, 3)));
	endfunction

	function automatic load_t rand_bits();
		logic [95:0] w;
		w = {$urandom(), $urandom(), $urandom()};
		return w[IN_W-1:0];
	endfunction

	// Directed table rows.
	function automatic void add_cfg(input int v);
		dir_row_t r;
		r.kind = ROW_CFG;
		r.op = OP_NONE;
		r.ld = '0;
		r.cfg = CFG_W'(v);
		r.typed = 1'b0;
		r.want = '0;
		dir_rows = {dir_rows, r};
	endfunction

	function automatic void add_item(input logic [OPC_W-1:0] op, input load_t ld);
		dir_row_t r;
		r.kind = ROW_ITEM;
		r.op = op;
		r.ld = ld;
		r.cfg = '0;
		r.typed = 1'b0;
		r.want = '0;
		dir_rows = {dir_rows, r};
	endfunction

	// A vote with its result written out by hand.
	function automatic void add_run(input logic win, input int va, input int vb,
			input logic err);
		dir_row_t r;
		r.kind = ROW_ITEM;
		r.op = OP_CLASS;
		r.ld = '0;
		r.cfg = '0;
		r.typed = 1'b1;
		r.want.zero = '0;
		r.want.winning_class = win;
		r.want.votes_a = VOTE_W'(va);
		r.want.votes_b = VOTE_W'(vb);
		r.want.depth_error = err;
		dir_rows = {dir_rows, r};
	endfunction

	// Offer one item, wait for it to be taken, then update the local copies
	// or queue the expected vote result.
	task automatic send_item(input logic [OPC_W-1:0] op, input load_t ld, input bit typed,
			input vote_t want);
		node_t nd;
		vote_t v;
		miss_t mk;
		int ma;
		if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ld;
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		if (op != OP_NONE)
			item_count++;
		case (op)
		OP_FEAT: begin
			if (ld.feature_index < NUM_FEATURES) begin
				feat_copy[ld.feature_index] = ld.feature_value;
				feat_written[ld.feature_index] = 1'b1;
			end
		end
		OP_NODE: begin
			if (ld.tree_number < MAX_TREES && ld.node_number < NODES_PER_TREE) begin
				nd.leaf = ld.node_is_leaf;
				nd.feature = ld.node_feature;
				nd.threshold = ld.node_threshold;
				nd.left = ld.left_child;
				nd.right = ld.right_child;
				nd.cls = ld.leaf_class;
				node_copy[int'(ld.tree_number) * NODES_PER_TREE + int'(ld.node_number)] = nd;
				node_written[int'(ld.tree_number) * NODES_PER_TREE + int'(ld.node_number)] = 1'b1;
			end
		end
		OP_CLASS: begin
			v = typed ? want : forest_vote(mk, ma);
			pending_votes = {pending_votes, v};
		end
		default: ;
		endcase
	endtask

	// Stop offering items until every vote result is back and the block is idle.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_votes.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		trees_reg = int'(v);
	endtask

	// Fill in every entry the next vote would read unwritten, then vote.
	task automatic run_forest();
		vote_t v;
		miss_t mk;
		int ma;
		v = forest_vote(mk, ma);
		while (mk != MISS_NONE) begin
			if (mk == MISS_FEAT)
				send_item(OP_FEAT, feat_item(ma, pick_word()), 1'b0, '0);
			else
				send_item(OP_NODE, random_node(ma / NODES_PER_TREE, ma % NODES_PER_TREE),
					1'b0, '0);
			v = forest_vote(mk, ma);
		end
		send_item(OP_CLASS, rand_bits(), 1'b0, '0);
	endtask

	// Result side: ready in stretches, stalled in short bursts, never in the tail.
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (quiet || $urandom_range(0, 3) != 0) begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	// Compare each vote result taken with the oldest expectation.
	always @(posedge clk) begin
		vote_t got;
		vote_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_votes.size() == 0) begin
				$error("vote result %h arrived with none expected", got);
				fail_count++;
			end else begin
				want = pending_votes.pop_front();
				if (got.winning_class !== want.winning_class) begin
					$error("winning_class: expected %0d, got %0d",
						want.winning_class, got.winning_class);
					fail_count++;
				end
				if (got.votes_a !== want.votes_a) begin
					$error("votes_a: expected %0d, got %0d", want.votes_a, got.votes_a);
					fail_count++;
				end
				if (got.votes_b !== want.votes_b) begin
					$error("votes_b: expected %0d, got %0d", want.votes_b, got.votes_b);
					fail_count++;
				end
				if (got.depth_error !== want.depth_error) begin
					$error("depth_error: expected %0d, got %0d",
						want.depth_error, got.depth_error);
					fail_count++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int n;
		int ep;
		int cfg_changes;
		int rand_start;
		int tree;
		int eff;
		int pick;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_NONE;
		trees_reg = int'(NUM_TREES_RST);
		feat_pool[0] = 0;
		feat_pool[1] = NUM_FEATURES - 1;
		for (int i = 2; i < POOL_SIZE; i++)
			feat_pool[i] = $urandom_range(0, NUM_FEATURES - 1);

		// Directed part: one or two small trees, every path through a walk.
		add_cfg(1);
		add_item(OP_FEAT, feat_item(0, 16'h0000));
		add_item(OP_FEAT, feat_item(NUM_FEATURES - 1, 16'hFFFF));
		// Feature equal to the threshold goes right.
		add_item(OP_NODE, node_item(0, 0, 1'b0, NUM_FEATURES - 1, 16'hFFFF, 1, 2, CLS_NONE));
		add_item(OP_NODE, node_item(0, 1, 1'b1, 0, 16'h0000, 0, 0, CLS_B));
		add_item(OP_NODE, node_item(0, 2, 1'b1, 0, 16'h0000, 0, 0, CLS_A));
		add_run(WIN_A, 1, 0, 1'b0);
		// Feature below the threshold goes left.
		add_item(OP_NODE, node_item(0, 0, 1'b0, 0, 16'h0001, 1, 2, CLS_NONE));
		add_run(WIN_B, 0, 1, 1'b0);
		// A leaf at node 0 counts only when the first step lands back on it.
		add_item(OP_NODE, node_item(0, 0, 1'b1, 0, 16'h0000, 0, 0, CLS_A));
		add_item(OP_NONE, '1);
		add_run(WIN_A, 1, 0, 1'b0);
		add_item(OP_NODE, node_item(0, 0, 1'b1, 0, 16'h0000, 0, 1, CLS_A));
		add_run(WIN_B, 0, 1, 1'b0);
		// A loop with no leaf runs into the depth bound.
		add_item(OP_NODE, node_item(0, 0, 1'b0, 0, 16'h0000, 0, 0, CLS_NONE));
		add_run(WIN_B, 0, 0, 1'b1);
		// Leaf classes 0 and 3 give no vote.
		add_item(OP_NODE, node_item(0, 3, 1'b1, 0, 16'h0000, 0, 0, CLS_SPARE));
		add_item(OP_NODE, node_item(0, 0, 1'b0, NUM_FEATURES - 1, 16'h0000, 0, 3, CLS_NONE));
		add_item(OP_NODE, node_item(MAX_TREES - 1, NODES_PER_TREE - 1, 1'b1,
			NUM_FEATURES - 1, 16'hFFFF, 255, 255, CLS_SPARE));
		add_cfg(2);
		add_item(OP_NODE, node_item(1, 4, 1'b1, 0, 16'h0000, 0, 0, CLS_NONE));
		add_item(OP_NODE, node_item(1, 0, 1'b0, 0, 16'hFFFF, 4, 0, CLS_NONE));
		add_run(WIN_B, 0, 0, 1'b0);
		add_item(OP_NODE, node_item(1, 4, 1'b1, 0, 16'h0000, 0, 0, CLS_A));
		add_item(OP_CLASS, '0);
		// No trees at all: B wins with no votes.
		add_cfg(0);
		add_run(WIN_B, 0, 0, 1'b0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				write_cfg(dir_rows[i].cfg);
			else
				send_item(dir_rows[i].op, dir_rows[i].ld, dir_rows[i].typed, dir_rows[i].want);
		end

		// Random part: episodes of loads into the active trees, then a vote.
		ep = 0;
		cfg_changes = 0;
		rand_start = item_count;
		while (item_count - rand_start < RANDOM_ITEMS) begin
			quiet = (item_count - rand_start) >= RANDOM_ITEMS - CALM_TAIL;
			calm = !quiet && $urandom_range(0, 3) == 0;
			if (ep == 0 || $urandom_range(0, 5) == 0) begin
				pick = $urandom_range(0, 15);
				if (cfg_changes == 0)
					write_cfg(8'd255);
				else if (cfg_changes == 3 || pick == 2)
					write_cfg(8'd128);
				else if (pick == 0)
					write_cfg(8'd0);
				else if (pick == 1)
					write_cfg(CFG_W'($urandom_range(129, 254)));
				else if (pick < 6)
					write_cfg(CFG_W'($urandom_range(1, MAX_TREES)));
				else
					write_cfg(CFG_W'($urandom_range(1, 6)));
				cfg_changes++;
			end
			eff = (trees_reg > MAX_TREES) ? MAX_TREES : trees_reg;
			n = $urandom_range(1, 10);
			repeat (n) begin
				tree = (eff == 0) ? $urandom_range(0, MAX_TREES - 1) : $urandom_range(0, eff - 1);
				case ($urandom_range(0, 9))
				0, 1, 2: begin
					send_item(OP_FEAT, feat_item(feat_pool[$urandom_range(0, POOL_SIZE - 1)],
						pick_word()), 1'b0, '0);
				end
				3, 4, 5, 6, 7: begin
					send_item(OP_NODE, random_node(tree, $urandom_range(0, 7)), 1'b0, '0);
				end
				// Stray load with every field random.
				8: begin
					send_item(($urandom_range(0, 1) != 0) ? OP_NODE : OP_FEAT, rand_bits(),
						1'b0, '0);
				end
				default: begin
					send_item(OP_NONE, rand_bits(), 1'b0, '0);
				end
				endcase
			end
			run_forest();
			ep++;
		end

		settle();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
